>>> hw/rtl/nosi_pkg.sv
// Shared types and command codes for the nearest-obstacle sorted table.
// Used by nosi_cell and nearest_obstacle_sorted_insert; no dependencies.
package nosi_pkg;

  // Command codes carried on in_command
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  // One obstacle record; key is the signed Q16.16 sort distance
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_z;
    logic signed [31:0] radius;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_z;
    logic signed [31:0] dvel_x;
    logic signed [31:0] dvel_z;
    logic signed [31:0] key;
  } rec_t;

  // Broadcast control from the table controller to every cell
  typedef struct packed {
    logic ins;  // insert transfer this cycle
    logic app;  // new record goes after all held entries
  } cell_ctl_t;

endpackage

>>> hw/rtl/nosi_cell.sv
// One slot of the sorted obstacle table: holds a record, compares its key
// with the incoming one and loads either the new record or its left neighbor.
// Depends on nosi_pkg.
module nosi_cell
  import nosi_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      slot_valid,  // slot index below the held count
  input  logic      hit_left,    // insert point lies at or left of the neighbor
  input  rec_t      new_rec,
  input  rec_t      left_rec,
  output rec_t      slot_rec,
  output logic      hit,         // insert point lies at or left of this slot
  output logic      key_gt       // held key greater than the new key
);

  rec_t slot_r;
  logic slot_lt;
  logic load_new;
  logic load_left;

  // Compare held key against the incoming key (signed)
  assign slot_lt = slot_r.key < new_rec.key;
  assign key_gt  = slot_valid & (new_rec.key < slot_r.key);

  // Empty slots always sit past the insert point; held ones when key >= new and not appending
  assign hit = ~slot_valid | (~ctl.app & ~slot_lt);

  // Take the new record at the insert point, shift right past it
  assign load_new  = ctl.ins & hit & ~hit_left;
  assign load_left = ctl.ins & hit_left;

  always_ff @(posedge clk) begin
    if (load_left) begin
      slot_r <= left_rec;
    end else if (load_new) begin
      slot_r <= new_rec;
    end
  end

  assign slot_rec = slot_r;

endmodule

>>> hw/rtl/nearest_obstacle_sorted_insert.sv
// Top level of the nearest-obstacle table: a row of nosi_cell slots kept in
// ascending distance order, count and capacity control, and the result register.
// Depends on nosi_pkg and nosi_cell.

// The block takes one command (clear, insert, read or no-op) in every clock
// cycle: busy is always low, and each command gives exactly one result on the
// out_ ports in the next cycle, marked by out_strobe for a single cycle. The
// receiver cannot stall, so results must be captured when the strobe is high.
// An insert compares its key against every slot cell at once and all cells
// shift in the same edge, so the compare and the append detect across the row
// of TABLE_DEPTH cells are combinational. Capacity must be written through
// cfg_wr_en/cfg_wr_data only while no command is in flight; the block does
// not enforce this. A value of 0 acts as 1, values above TABLE_DEPTH act as
// TABLE_DEPTH, and lowering it trims the held entries. Slot contents are not
// cleared at reset; only slots below the entry count are ever returned.
module nearest_obstacle_sorted_insert
  import nosi_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic [4:0]         in_read_index,
  input  logic signed [31:0] in_obstacle_pos_x,
  input  logic signed [31:0] in_obstacle_pos_z,
  input  logic signed [31:0] in_obstacle_radius,
  input  logic signed [31:0] in_obstacle_vel_x,
  input  logic signed [31:0] in_obstacle_vel_z,
  input  logic signed [31:0] in_obstacle_dvel_x,
  input  logic signed [31:0] in_obstacle_dvel_z,
  input  logic signed [31:0] in_obstacle_dist,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [5:0]         cfg_wr_data,
  // result channel
  output logic               out_strobe,
  output logic [5:0]         out_entry_count,
  output logic               out_was_stored,
  output logic               out_was_evicted,
  output logic               out_read_valid,
  output logic signed [31:0] out_entry_pos_x,
  output logic signed [31:0] out_entry_pos_z,
  output logic signed [31:0] out_entry_radius,
  output logic signed [31:0] out_entry_vel_x,
  output logic signed [31:0] out_entry_vel_z,
  output logic signed [31:0] out_entry_dvel_x,
  output logic signed [31:0] out_entry_dvel_z,
  output logic signed [31:0] out_entry_dist
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [CNT_W-1:0] held_r, held_nxt;
  logic [CNT_W-1:0] cap_r, cap_nxt;
  logic             strobe_r;
  logic [5:0]       count_out_r;
  logic             stored_r, stored_nxt;
  logic             evicted_r, evicted_nxt;
  logic             rvalid_r, rvalid_nxt;
  rec_t             shown_r, shown_nxt;

  rec_t             new_rec;
  rec_t             rd_rec;
  cell_ctl_t        ctl;
  logic             xfer;
  logic             any_gt;
  logic             is_full;

  rec_t             slot_q   [TABLE_DEPTH];
  logic             hit_v    [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] gt_v;

  assign busy = 1'b0;
  assign xfer = start & ~busy;

  assign new_rec = '{pos_x:  in_obstacle_pos_x,  pos_z:  in_obstacle_pos_z,
                     radius: in_obstacle_radius, vel_x:  in_obstacle_vel_x,
                     vel_z:  in_obstacle_vel_z,  dvel_x: in_obstacle_dvel_x,
                     dvel_z: in_obstacle_dvel_z, key:    in_obstacle_dist};

  // Append when the table holds entries and no held key is greater than the new one
  assign any_gt  = |gt_v;
  assign is_full = held_r >= cap_r;
  assign ctl.ins = xfer & (in_command == CMD_INSERT);
  assign ctl.app = (held_r != '0) & ~any_gt;

  // Row of slot cells, each fed by its left neighbor; the first is fed by the new record
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic slot_valid;
    logic hit_left;
    rec_t left_rec;

    assign slot_valid = CNT_W'(i) < held_r;
    if (i == 0) begin : g_first
      assign hit_left = 1'b0;
      assign left_rec = new_rec;
    end else begin : g_rest
      assign hit_left = hit_v[i-1];
      assign left_rec = slot_q[i-1];
    end

    nosi_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .slot_valid (slot_valid),
      .hit_left   (hit_left),
      .new_rec    (new_rec),
      .left_rec   (left_rec),
      .slot_rec   (slot_q[i]),
      .hit        (hit_v[i]),
      .key_gt     (gt_v[i])
    );
  end

  // Select the addressed slot for a read
  always_comb begin
    rd_rec = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (32'(in_read_index) == i) begin
        rd_rec = slot_q[i];
      end
    end
  end

  // Count, flags and read data for the command being transferred
  always_comb begin
    held_nxt    = held_r;
    cap_nxt     = cap_r;
    stored_nxt  = 1'b0;
    evicted_nxt = 1'b0;
    rvalid_nxt  = 1'b0;
    shown_nxt   = '0;
    if (xfer) begin
      case (in_command)
        CMD_CLEAR: begin
          held_nxt = '0;
        end
        CMD_INSERT: begin
          if (held_r == '0) begin
            held_nxt   = CNT_W'(1);
            stored_nxt = 1'b1;
          end else if (ctl.app) begin
            if (!is_full) begin
              held_nxt   = held_r + CNT_W'(1);
              stored_nxt = 1'b1;
            end
          end else begin
            stored_nxt = 1'b1;
            if (!is_full) begin
              held_nxt = held_r + CNT_W'(1);
            end else begin
              evicted_nxt = 1'b1;
            end
          end
        end
        CMD_READ: begin
          if ((CNT_W + 1)'(in_read_index) < {1'b0, held_r} &&
              32'(in_read_index) < TABLE_DEPTH) begin
            rvalid_nxt = 1'b1;
            shown_nxt  = rd_rec;
          end
        end
        default: begin
          held_nxt = held_r;
        end
      endcase
    end
    // Clamp capacity and trim held entries on a write
    if (cfg_wr_en) begin
      if (cfg_wr_data == 6'd0) begin
        cap_nxt = CNT_W'(1);
      end else if (32'(cfg_wr_data) > TABLE_DEPTH) begin
        cap_nxt = CNT_W'(TABLE_DEPTH);
      end else begin
        cap_nxt = CNT_W'(cfg_wr_data);
      end
      if (held_r > cap_nxt) begin
        held_nxt = cap_nxt;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= '0;
      cap_r    <= CNT_W'(TABLE_DEPTH);
      strobe_r <= 1'b0;
    end else begin
      held_r   <= held_nxt;
      cap_r    <= cap_nxt;
      strobe_r <= xfer;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    count_out_r <= 6'(held_nxt);
    stored_r    <= stored_nxt;
    evicted_r   <= evicted_nxt;
    rvalid_r    <= rvalid_nxt;
    shown_r     <= shown_nxt;
  end

  assign out_strobe       = strobe_r;
  assign out_entry_count  = count_out_r;
  assign out_was_stored   = stored_r;
  assign out_was_evicted  = evicted_r;
  assign out_read_valid   = rvalid_r;
  assign out_entry_pos_x  = shown_r.pos_x;
  assign out_entry_pos_z  = shown_r.pos_z;
  assign out_entry_radius = shown_r.radius;
  assign out_entry_vel_x  = shown_r.vel_x;
  assign out_entry_vel_z  = shown_r.vel_z;
  assign out_entry_dvel_x = shown_r.dvel_x;
  assign out_entry_dvel_z = shown_r.dvel_z;
  assign out_entry_dist   = shown_r.key;

  // Held count never exceeds the capacity in use, and the capacity is never zero
  a_count_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= cap_r && cap_r != '0)
    else $error("held count above capacity");

  // Every transfer yields one result on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    xfer |=> out_strobe)
    else $error("missing result strobe");

  // An eviction only happens on a stored insert into a full table
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && evicted_nxt |-> stored_nxt && held_nxt == held_r && held_r == cap_r)
    else $error("eviction without a full table");

  // Read data shows only on a valid read
  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !rvalid_nxt |-> shown_nxt == '0)
    else $error("entry data without a valid read");

endmodule
